FILE: hdl/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int unsigned NumMotorsDef = 2;

  localparam int unsigned TickW  = 16;
  localparam int unsigned SprW   = 13;
  localparam int unsigned AngleW = 16;
  localparam int unsigned StepsW = 19;
  localparam int unsigned CoilW  = 4;
  localparam int unsigned PatW   = 3;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTicksPerPhase = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStepsPerRev   = 1'b1;

  localparam logic [TickW-1:0] TicksPerPhaseRst = 16'd10;
  localparam logic [SprW-1:0]  StepsPerRevRst   = 13'd512;

  // opcodes
  localparam logic OpTick   = 1'b0;
  localparam logic OpRotate = 1'b1;

  // rounding of |angle| * steps_per_rev / 360
  localparam int unsigned ProdW    = AngleW + SprW;     // 29
  localparam int unsigned HalfDeg  = 180;
  localparam int unsigned QuotW    = StepsW + 2;        // 21
  localparam int unsigned DivW     = ProdW - 3;         // 26, after the divide by 8
  localparam int unsigned RecipSh  = 31;
  localparam int unsigned RecipW   = 26;
  // floor(2^31 / 45)
  localparam logic [RecipW-1:0] Recip45 = 26'd47721858;
  localparam int unsigned Div45    = 45;

  localparam logic [StepsW-1:0] StepsMax = {StepsW{1'b1}};

  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;

  function automatic logic [CoilW-1:0] coil_pattern(input logic rev,
                                                    input logic [PatW-1:0] idx);
    logic [CoilW-1:0] p;
    case (idx)
      3'd0: p = 4'h8;
      3'd1: p = 4'hC;
      3'd2: p = 4'h4;
      3'd3: p = 4'h6;
      3'd4: p = 4'h2;
      3'd5: p = 4'h3;
      3'd6: p = 4'h1;
      3'd7: p = 4'h9;
      default: p = 4'h0;
    endcase
    if (rev) begin
      // reverse order is the forward table read backwards
      case (idx)
        3'd0: p = 4'h9;
        3'd1: p = 4'h1;
        3'd2: p = 4'h3;
        3'd3: p = 4'h2;
        3'd4: p = 4'h6;
        3'd5: p = 4'h4;
        3'd6: p = 4'hC;
        3'd7: p = 4'h8;
        default: p = 4'h0;
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/stepper_half_step_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                  payload
// s_axis    in   tvalid / tready            tuser: opcode, motor_select; tdata: angle
// m_axis    out  tvalid / tready            tdata: coils, busy flags, accepted, command_steps
// cfg       in   cfg_we_i, no back-pressure cfg_idx_i, cfg_data_i
//
// one word per cycle sustained while m_axis_tready is high; from input to result: multiply by
// steps_per_rev, reciprocal multiply for the divide by 360, then correction and
// motor state update into the output register.
// each stage holds under back-pressure and empty stages fill while the output waits.
// reset turns all coils off, stops all motors and loads the register defaults.

module stepper_half_step_sequencer
  import stp_pkg::*;
#(
  parameter int unsigned NUM_MOTORS = NumMotorsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [15:0] angle
  input  wire logic [InUserW-1:0]  s_axis_tuser,   // [0] opcode, [1] motor_select

  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [3:0] pitch_coils, [7:4] yaw_coils, [8] pitch_busy, [9] yaw_busy,
  // [10] accepted, [29:11] command_steps, [31:30] zero
  output      logic [OutDataW-1:0] m_axis_tdata,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef struct packed {
    logic op;
    logic sel;
    logic rev;
  } cmd_t;

  // configuration
  logic [TickW-1:0] tpp_q;
  logic [SprW-1:0]  spr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q <= TicksPerPhaseRst;
      spr_q <= StepsPerRevRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTicksPerPhase: tpp_q <= cfg_data_i[TickW-1:0];
        RegStepsPerRev:   spr_q <= cfg_data_i[SprW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || m_axis_tready;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // stage 1: input register
  cmd_t              c1_q;
  logic [AngleW-1:0] ang1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q.op  <= s_axis_tuser[0];
      c1_q.sel <= s_axis_tuser[1];
      c1_q.rev <= s_axis_tdata[AngleW-1] || (s_axis_tdata[AngleW-1:0] == '0);
      ang1_q   <= s_axis_tdata[AngleW-1:0];
    end
  end

  logic [AngleW-1:0] mag1;
  logic [ProdW-1:0]  x1;

  assign mag1 = ang1_q[AngleW-1] ? (~ang1_q + 1'b1) : ang1_q;
  assign x1   = ProdW'(mag1) * ProdW'(spr_q) + ProdW'(HalfDeg);

  // stage 2: product plus half, divide by 8 then by 45
  cmd_t            c2_q;
  logic [DivW-1:0] y2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      c2_q <= c1_q;
      y2_q <= x1[ProdW-1:3];
    end
  end

  logic [DivW+RecipW-1:0] p2;
  assign p2 = (DivW+RecipW)'(y2_q) * (DivW+RecipW)'(Recip45);

  // stage 3: quotient estimate, low by at most one
  cmd_t             c3_q;
  logic [DivW-1:0]  y3_q;
  logic [QuotW-1:0] q3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      c3_q <= c2_q;
      y3_q <= y2_q;
      q3_q <= p2[RecipSh +: QuotW];
    end
  end

  logic [DivW+1:0]  qm45;
  logic [DivW+1:0]  rem3;
  logic [QuotW-1:0] quot3;
  logic [StepsW-1:0] steps3;

  always_comb begin
    qm45  = ((DivW+2)'(q3_q) << 5) + ((DivW+2)'(q3_q) << 3)
          + ((DivW+2)'(q3_q) << 2) + (DivW+2)'(q3_q);
    rem3  = (DivW+2)'(y3_q) - qm45;
    quot3 = q3_q + QuotW'(rem3 >= (DivW+2)'(Div45));
    steps3 = (quot3 > QuotW'(StepsMax)) ? StepsMax : quot3[StepsW-1:0];
  end

  // per-motor state
  logic [NUM_MOTORS-1:0] run_q,  run_d;
  logic [NUM_MOTORS-1:0] rev_q,  rev_d;
  logic [NUM_MOTORS-1:0] take;
  logic [PatW-1:0]   pat_q   [NUM_MOTORS];
  logic [PatW-1:0]   pat_d   [NUM_MOTORS];
  logic [StepsW-1:0] left_q  [NUM_MOTORS];
  logic [StepsW-1:0] left_d  [NUM_MOTORS];
  logic [TickW-1:0]  hold_q  [NUM_MOTORS];
  logic [TickW-1:0]  hold_d  [NUM_MOTORS];
  logic [CoilW-1:0]  coil_q  [NUM_MOTORS];
  logic [CoilW-1:0]  coil_d  [NUM_MOTORS];

  logic fire3;
  assign fire3 = v3_q && eno;

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
    logic             hit;
    logic [TickW-1:0] hold_inc;
    logic [StepsW-1:0] left_dec;

    assign hit      = (c3_q.op == OpRotate) && (32'(c3_q.sel) == m);
    assign take[m]  = hit && !run_q[m];
    assign hold_inc = hold_q[m] + 1'b1;
    assign left_dec = (left_q[m] != '0) ? left_q[m] - 1'b1 : '0;

    always_comb begin
      run_d[m]  = run_q[m];
      rev_d[m]  = rev_q[m];
      pat_d[m]  = pat_q[m];
      left_d[m] = left_q[m];
      hold_d[m] = hold_q[m];
      coil_d[m] = coil_q[m];
      if (c3_q.op == OpTick) begin
        if (run_q[m]) begin
          if (hold_inc < tpp_q) begin
            hold_d[m] = hold_inc;
          end else begin
            hold_d[m] = '0;
            if (pat_q[m] == '1) begin
              left_d[m] = left_dec;
              pat_d[m]  = '0;
              if (left_dec == '0) begin
                run_d[m]  = 1'b0;
                coil_d[m] = '0;
              end else begin
                coil_d[m] = coil_pattern(rev_q[m], '0);
              end
            end else begin
              pat_d[m]  = pat_q[m] + 1'b1;
              coil_d[m] = coil_pattern(rev_q[m], pat_q[m] + 1'b1);
            end
          end
        end
      end else if (take[m]) begin
        rev_d[m]  = c3_q.rev;
        pat_d[m]  = '0;
        hold_d[m] = '0;
        left_d[m] = steps3;
        run_d[m]  = (steps3 != '0);
        coil_d[m] = (steps3 != '0) ? coil_pattern(c3_q.rev, '0) : '0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        run_q[m]  <= 1'b0;
        rev_q[m]  <= 1'b0;
        pat_q[m]  <= '0;
        left_q[m] <= '0;
        hold_q[m] <= '0;
        coil_q[m] <= '0;
      end else if (fire3) begin
        run_q[m]  <= run_d[m];
        rev_q[m]  <= rev_d[m];
        pat_q[m]  <= pat_d[m];
        left_q[m] <= left_d[m];
        hold_q[m] <= hold_d[m];
        coil_q[m] <= coil_d[m];
      end
    end
  end

  // result word
  logic [CoilW-1:0]  yaw_coils;
  logic              yaw_busy;
  logic              acc3;
  logic [OutDataW-1:0] out_d;
  logic [OutDataW-1:0] out_q;

  if (NUM_MOTORS > 1) begin : g_yaw
    assign yaw_coils = coil_d[NUM_MOTORS > 1 ? 1 : 0];
    assign yaw_busy  = run_d[NUM_MOTORS > 1 ? 1 : 0];
  end else begin : g_no_yaw
    assign yaw_coils = '0;
    assign yaw_busy  = 1'b0;
  end

  assign acc3  = |take;
  assign out_d = {2'b00, (acc3 ? steps3 : {StepsW{1'b0}}), acc3, yaw_busy, run_d[0],
                  yaw_coils, coil_d[0]};

  always_ff @(posedge clk_i) begin
    if (eno) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
